>>> sv/hapd_pkg.sv
// ----------------------------------------------------------------------------
// hapd_pkg
// Shared types, register indexes and timing constants of the haptic alert
// output driver.
// ----------------------------------------------------------------------------
package hapd_pkg;

    localparam int unsigned TIME_WIDTH_DEF = 32;

    localparam int unsigned CFG_DATA_WIDTH  = 24;
    localparam int unsigned CFG_INDEX_WIDTH = 3;
    localparam int unsigned COLOUR_WIDTH    = 24;
    localparam int unsigned PERIOD_WIDTH    = 16;
    localparam int unsigned DUTY_WIDTH      = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COLOUR_SAFE      = 3'd0,
        REG_COLOUR_ALERT     = 3'd1,
        REG_COLOUR_WARNING   = 3'd2,
        REG_COLOUR_DANGER    = 3'd3,
        REG_STRENGTH_LEVELS  = 3'd4,
        REG_GPS_BLINK_PERIOD = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        LEVEL_SAFE    = 2'd0,
        LEVEL_ALERT   = 2'd1,
        LEVEL_WARNING = 2'd2,
        LEVEL_DANGER  = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        STYLE_STRENGTH = 2'd0,
        STYLE_PULSE    = 2'd1,
        STYLE_TAP      = 2'd2
    } style_t;

    localparam logic [PERIOD_WIDTH-1:0] BLINK_PERIOD_RESET = 16'd500;

    localparam logic [DUTY_WIDTH-1:0] DUTY_ON  = 8'd255;
    localparam logic [DUTY_WIDTH-1:0] DUTY_OFF = 8'd0;

    // phase counter periods
    localparam logic [10:0] PERIOD_1200 = 11'd1200;
    localparam logic [9:0]  PERIOD_800  = 10'd800;
    localparam logic [10:0] PERIOD_2000 = 11'd2000;
    localparam logic [9:0]  PERIOD_1000 = 10'd1000;

    // pulse on-times
    localparam logic [10:0] PULSE_ALERT_ON   = 11'd200;
    localparam logic [9:0]  PULSE_WARNING_ON = 10'd400;

    // tap pattern edges
    localparam logic [10:0] TAP_END_1   = 11'd150;
    localparam logic [10:0] TAP_START_2 = 11'd300;
    localparam logic [10:0] TAP_END_2   = 11'd450;
    localparam logic [9:0]  TRI_END_1   = 10'd100;
    localparam logic [9:0]  TRI_START_2 = 10'd200;
    localparam logic [9:0]  TRI_END_2   = 10'd300;
    localparam logic [9:0]  TRI_START_3 = 10'd400;
    localparam logic [9:0]  TRI_END_3   = 10'd500;

    typedef struct packed {
        logic [COLOUR_WIDTH-1:0] colour_safe;
        logic [COLOUR_WIDTH-1:0] colour_alert;
        logic [COLOUR_WIDTH-1:0] colour_warning;
        logic [COLOUR_WIDTH-1:0] colour_danger;
        logic [COLOUR_WIDTH-1:0] strength_levels;
        logic [PERIOD_WIDTH-1:0] gps_blink_period;
    } cfg_t;

    typedef struct packed {
        logic [10:0] p1200;
        logic [9:0]  p800;
        logic [10:0] p2000;
        logic [9:0]  p1000;
    } phase_t;

endpackage

>>> sv/haptic_alert_output_driver.sv
// ----------------------------------------------------------------------------
// haptic_alert_output_driver
// Per-millisecond motor duty, collision LED colour and GPS LED driver.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  ------------------------------------------------------------------------
//  tick in   in_valid / in_ready       alert_level, vib_style, gps_show,
//                                      gps_valid
//  result    out_valid / out_ready     motor_duty, led_red, led_green,
//                                      led_blue, gps_led
//  config    cfg_write (no wait)       cfg_index, cfg_data
//
//  each tick beat is held in an input register, decoded combinationally
//  and lands in the result register; one beat per cycle while results
//  are taken. time and phase counters advance as a beat moves into the
//  result register. a stalled result holds both registers; the input
//  register still takes a beat while the result register is waiting only
//  if it is empty. reset clears counters and loads the register defaults.
// ----------------------------------------------------------------------------
module haptic_alert_output_driver
#(
    parameter int unsigned TIME_WIDTH = hapd_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           alert_level,
    input  logic [1:0]                           vib_style,
    input  logic                                 gps_show,
    input  logic                                 gps_valid,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           motor_duty,
    output logic [7:0]                           led_red,
    output logic [7:0]                           led_green,
    output logic [7:0]                           led_blue,
    output logic                                 gps_led,
    input  logic                                 cfg_write,
    input  logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hapd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    hapd_pkg::cfg_t   cfg;
    hapd_pkg::phase_t phase;

    logic             stage_valid_reg;
    hapd_pkg::level_t level_reg;
    hapd_pkg::style_t style_reg;
    logic             show_reg;
    logic             fix_reg;

    logic             out_valid_reg;
    logic [7:0]       duty_reg;
    logic [23:0]      colour_reg;
    logic             gps_led_reg;

    logic             out_free;
    logic             advance;
    logic             in_accept;
    logic [7:0]       duty_next;
    logic [23:0]      colour_next;
    logic             gps_led_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = stage_valid_reg && out_free;
    assign in_ready  = !stage_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;

    hapd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hapd_state #(.TIME_WIDTH(TIME_WIDTH)) u_state
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .gps_show     (show_reg),
        .gps_valid    (fix_reg),
        .blink_period (cfg.gps_blink_period),
        .phase        (phase),
        .gps_led_next (gps_led_next)
    );

    hapd_motor u_motor
    (
        .level           (level_reg),
        .style           (style_reg),
        .phase           (phase),
        .strength_levels (cfg.strength_levels),
        .motor_duty      (duty_next)
    );

    always_comb
    begin
        case (level_reg)
            hapd_pkg::LEVEL_ALERT:   colour_next = cfg.colour_alert;
            hapd_pkg::LEVEL_WARNING: colour_next = cfg.colour_warning;
            hapd_pkg::LEVEL_DANGER:  colour_next = cfg.colour_danger;
            default:                 colour_next = cfg.colour_safe;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg <= hapd_pkg::level_t'(alert_level);
            style_reg <= hapd_pkg::style_t'(vib_style);
            show_reg  <= gps_show;
            fix_reg   <= gps_valid;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_reg    <= duty_next;
            colour_reg  <= colour_next;
            gps_led_reg <= gps_led_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign motor_duty = duty_reg;
    assign led_red    = colour_reg[23:16];
    assign led_green  = colour_reg[15:8];
    assign led_blue   = colour_reg[7:0];
    assign gps_led    = gps_led_reg;

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_safe_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && level_reg == hapd_pkg::LEVEL_SAFE) |=> (motor_duty == 8'd0))
        else $error("motor driven at safe level");

    a_gps_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !show_reg) |=> !gps_led)
        else $error("gps led lit while hidden");

    a_gps_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && show_reg && fix_reg) |=> gps_led)
        else $error("gps led dark with valid fix");

endmodule

>>> sv/hapd_cfg.sv
// ----------------------------------------------------------------------------
// hapd_cfg
// Configuration register file: colours, strength bytes and blink period.
// ----------------------------------------------------------------------------
module hapd_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hapd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output hapd_pkg::cfg_t                       cfg
);

    hapd_pkg::cfg_t cfg_reg;
    hapd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (hapd_pkg::reg_index_t'(cfg_index))
                hapd_pkg::REG_COLOUR_SAFE:      cfg_next.colour_safe     = cfg_data;
                hapd_pkg::REG_COLOUR_ALERT:     cfg_next.colour_alert    = cfg_data;
                hapd_pkg::REG_COLOUR_WARNING:   cfg_next.colour_warning  = cfg_data;
                hapd_pkg::REG_COLOUR_DANGER:    cfg_next.colour_danger   = cfg_data;
                hapd_pkg::REG_STRENGTH_LEVELS:  cfg_next.strength_levels = cfg_data;
                hapd_pkg::REG_GPS_BLINK_PERIOD:
                    cfg_next.gps_blink_period = cfg_data[hapd_pkg::PERIOD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{colour_safe:      '0,
                         colour_alert:     '0,
                         colour_warning:   '0,
                         colour_danger:    '0,
                         strength_levels:  '0,
                         gps_blink_period: hapd_pkg::BLINK_PERIOD_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/hapd_state.sv
// ----------------------------------------------------------------------------
// hapd_state
// Millisecond time, phase counters and GPS LED blink state, advanced once
// per processed tick.
// ----------------------------------------------------------------------------
module hapd_state
#(
    parameter int unsigned TIME_WIDTH = hapd_pkg::TIME_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              gps_show,
    input  logic                              gps_valid,
    input  logic [hapd_pkg::PERIOD_WIDTH-1:0] blink_period,
    output hapd_pkg::phase_t                  phase,
    output logic                              gps_led_next
);

    logic [TIME_WIDTH-1:0] ms_count_reg;
    logic [TIME_WIDTH-1:0] ms_count_next;
    logic [TIME_WIDTH-1:0] last_toggle_reg;
    logic [TIME_WIDTH-1:0] last_toggle_next;
    logic                  blink_reg;
    logic                  blink_next;
    logic                  gps_pin_reg;
    hapd_pkg::phase_t      phase_reg;
    hapd_pkg::phase_t      phase_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  toggle;

    // elapsed time wraps with the counter width
    assign elapsed = ms_count_reg - last_toggle_reg;
    assign toggle  = gps_show && !gps_valid &&
                     (elapsed >= TIME_WIDTH'(blink_period));

    always_comb
    begin
        if (!gps_show)
        begin
            gps_led_next = 1'b0;
        end
        else if (gps_valid)
        begin
            gps_led_next = 1'b1;
        end
        else if (toggle)
        begin
            gps_led_next = ~blink_reg;
        end
        else
        begin
            gps_led_next = gps_pin_reg;
        end
    end

    always_comb
    begin
        ms_count_next    = ms_count_reg + TIME_WIDTH'(1);
        last_toggle_next = toggle ? ms_count_reg : last_toggle_reg;
        blink_next       = toggle ? ~blink_reg : blink_reg;

        phase_next.p1200 = (phase_reg.p1200 + 11'd1 >= hapd_pkg::PERIOD_1200) ?
                           11'd0 : phase_reg.p1200 + 11'd1;
        phase_next.p800  = (phase_reg.p800 + 10'd1 >= hapd_pkg::PERIOD_800) ?
                           10'd0 : phase_reg.p800 + 10'd1;
        phase_next.p2000 = (phase_reg.p2000 + 11'd1 >= hapd_pkg::PERIOD_2000) ?
                           11'd0 : phase_reg.p2000 + 11'd1;
        phase_next.p1000 = (phase_reg.p1000 + 10'd1 >= hapd_pkg::PERIOD_1000) ?
                           10'd0 : phase_reg.p1000 + 10'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_count_reg    <= '0;
            last_toggle_reg <= '0;
            blink_reg       <= 1'b0;
            gps_pin_reg     <= 1'b0;
            phase_reg       <= '0;
        end
        else if (step)
        begin
            ms_count_reg    <= ms_count_next;
            last_toggle_reg <= last_toggle_next;
            blink_reg       <= blink_next;
            gps_pin_reg     <= gps_led_next;
            phase_reg       <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

>>> sv/hapd_motor.sv
// ----------------------------------------------------------------------------
// hapd_motor
// Motor duty decode from alert level, vibration style and phase counters.
// ----------------------------------------------------------------------------
module hapd_motor
(
    input  hapd_pkg::level_t                  level,
    input  hapd_pkg::style_t                  style,
    input  hapd_pkg::phase_t                  phase,
    input  logic [hapd_pkg::COLOUR_WIDTH-1:0] strength_levels,
    output logic [hapd_pkg::DUTY_WIDTH-1:0]   motor_duty
);

    logic pulse_on;
    logic tap_on;
    logic tap_2000;
    logic tap_1000;
    logic tri_800;
    logic [hapd_pkg::DUTY_WIDTH-1:0] strength;

    assign tap_2000 = (phase.p2000 < hapd_pkg::TAP_END_1) ||
                      (phase.p2000 >= hapd_pkg::TAP_START_2 &&
                       phase.p2000 < hapd_pkg::TAP_END_2);
    assign tap_1000 = (11'(phase.p1000) < hapd_pkg::TAP_END_1) ||
                      (11'(phase.p1000) >= hapd_pkg::TAP_START_2 &&
                       11'(phase.p1000) < hapd_pkg::TAP_END_2);
    assign tri_800  = (phase.p800 < hapd_pkg::TRI_END_1) ||
                      (phase.p800 >= hapd_pkg::TRI_START_2 &&
                       phase.p800 < hapd_pkg::TRI_END_2) ||
                      (phase.p800 >= hapd_pkg::TRI_START_3 &&
                       phase.p800 < hapd_pkg::TRI_END_3);

    always_comb
    begin
        case (level)
            hapd_pkg::LEVEL_ALERT:
            begin
                strength = strength_levels[23:16];
                pulse_on = phase.p1200 < hapd_pkg::PULSE_ALERT_ON;
                tap_on   = tap_2000;
            end
            hapd_pkg::LEVEL_WARNING:
            begin
                strength = strength_levels[15:8];
                pulse_on = phase.p800 < hapd_pkg::PULSE_WARNING_ON;
                tap_on   = tap_1000;
            end
            hapd_pkg::LEVEL_DANGER:
            begin
                strength = strength_levels[7:0];
                pulse_on = 1'b1;
                tap_on   = tri_800;
            end
            default:
            begin
                strength = hapd_pkg::DUTY_OFF;
                pulse_on = 1'b0;
                tap_on   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (style)
            hapd_pkg::STYLE_STRENGTH: motor_duty = strength;
            hapd_pkg::STYLE_PULSE:
                motor_duty = pulse_on ? hapd_pkg::DUTY_ON : hapd_pkg::DUTY_OFF;
            hapd_pkg::STYLE_TAP:
                motor_duty = tap_on ? hapd_pkg::DUTY_ON : hapd_pkg::DUTY_OFF;
            default: motor_duty = hapd_pkg::DUTY_OFF;
        endcase
    end

endmodule

>>> dv/tb_haptic_alert_output_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haptic_alert_output_driver
// Self-checking bench for the haptic alert output driver. Millisecond tick
// beats go in over a valid/ready channel with random gaps. A scoreboard keeps
// its own time and phase counters, blink state and register copy, predicts
// every result beat and checks it against the result channel. The result side
// stalls at random and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_haptic_alert_output_driver;

    localparam int unsigned TW            = hapd_pkg::TIME_WIDTH_DEF;
    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned PHASE_TICKS   = 90;
    localparam int unsigned RANDOM_PHASES = 5;

    // indexes past the register map, writes there must be dropped
    localparam logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
    localparam logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;
    // style code with no meaning, gives a silent motor
    localparam logic [1:0] STYLE_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       gps;
    } drive_out_t;

    class haptic_scoreboard;
        hapd_pkg::cfg_t   cfg;
        logic [TW-1:0]    ms_now;
        logic [TW-1:0]    last_flip_ms;
        hapd_pkg::phase_t ph;
        logic             flip_state;
        logic             pin_state;
        drive_out_t       due_q[$];
        int unsigned      failures;

        function new();
            cfg.colour_safe      = '0;
            cfg.colour_alert     = '0;
            cfg.colour_warning   = '0;
            cfg.colour_danger    = '0;
            cfg.strength_levels  = '0;
            cfg.gps_blink_period = hapd_pkg::BLINK_PERIOD_RESET;
            ms_now       = '0;
            last_flip_ms = '0;
            ph           = '0;
            flip_state   = 1'b0;
            pin_state    = 1'b0;
            failures     = 0;
        endfunction

        function void write_reg(logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                logic [hapd_pkg::CFG_DATA_WIDTH-1:0] data);
            case (idx)
                hapd_pkg::REG_COLOUR_SAFE:      cfg.colour_safe      = data;
                hapd_pkg::REG_COLOUR_ALERT:     cfg.colour_alert     = data;
                hapd_pkg::REG_COLOUR_WARNING:   cfg.colour_warning   = data;
                hapd_pkg::REG_COLOUR_DANGER:    cfg.colour_danger    = data;
                hapd_pkg::REG_STRENGTH_LEVELS:  cfg.strength_levels  = data;
                hapd_pkg::REG_GPS_BLINK_PERIOD:
                    cfg.gps_blink_period = data[hapd_pkg::PERIOD_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function logic double_tap_on(logic [10:0] c);
            return (c < hapd_pkg::TAP_END_1) ||
                   (c >= hapd_pkg::TAP_START_2 && c < hapd_pkg::TAP_END_2);
        endfunction

        function void note_tick(hapd_pkg::level_t lv, logic [1:0] st, logic sh, logic vd);
            drive_out_t                        d;
            logic [hapd_pkg::COLOUR_WIDTH-1:0] colour;
            logic                              on;
            on = 1'b0;
            case (lv)
                hapd_pkg::LEVEL_ALERT:   colour = cfg.colour_alert;
                hapd_pkg::LEVEL_WARNING: colour = cfg.colour_warning;
                hapd_pkg::LEVEL_DANGER:  colour = cfg.colour_danger;
                default:                 colour = cfg.colour_safe;
            endcase
            d.red   = colour[23:16];
            d.green = colour[15:8];
            d.blue  = colour[7:0];

            d.duty = hapd_pkg::DUTY_OFF;
            if (lv != hapd_pkg::LEVEL_SAFE) begin
                case (st)
                    hapd_pkg::STYLE_STRENGTH:
                    begin
                        case (lv)
                            hapd_pkg::LEVEL_ALERT:   d.duty = cfg.strength_levels[23:16];
                            hapd_pkg::LEVEL_WARNING: d.duty = cfg.strength_levels[15:8];
                            default:                 d.duty = cfg.strength_levels[7:0];
                        endcase
                    end
                    hapd_pkg::STYLE_PULSE:
                    begin
                        case (lv)
                            hapd_pkg::LEVEL_ALERT:
                                on = ph.p1200 < hapd_pkg::PULSE_ALERT_ON;
                            hapd_pkg::LEVEL_WARNING:
                                on = ph.p800 < hapd_pkg::PULSE_WARNING_ON;
                            default:
                                on = 1'b1;
                        endcase
                        d.duty = on ? hapd_pkg::DUTY_ON : hapd_pkg::DUTY_OFF;
                    end
                    hapd_pkg::STYLE_TAP:
                    begin
                        case (lv)
                            hapd_pkg::LEVEL_ALERT:   on = double_tap_on(ph.p2000);
                            hapd_pkg::LEVEL_WARNING: on = double_tap_on({1'b0, ph.p1000});
                            default:
                                on = (ph.p800 < hapd_pkg::TRI_END_1) ||
                                     (ph.p800 >= hapd_pkg::TRI_START_2 &&
                                      ph.p800 < hapd_pkg::TRI_END_2) ||
                                     (ph.p800 >= hapd_pkg::TRI_START_3 &&
                                      ph.p800 < hapd_pkg::TRI_END_3);
                        endcase
                        d.duty = on ? hapd_pkg::DUTY_ON : hapd_pkg::DUTY_OFF;
                    end
                    default: d.duty = hapd_pkg::DUTY_OFF;
                endcase
            end

            if (!sh) begin
                pin_state = 1'b0;
            end
            else if (vd) begin
                pin_state = 1'b1;
            end
            else if (TW'(ms_now - last_flip_ms) >= TW'(cfg.gps_blink_period)) begin
                last_flip_ms = ms_now;
                flip_state   = ~flip_state;
                pin_state    = flip_state;
            end
            d.gps = pin_state;
            due_q.push_back(d);

            ms_now  = ms_now + 1'b1;
            ph.p1200 = (ph.p1200 == hapd_pkg::PERIOD_1200 - 1) ? '0 : ph.p1200 + 1'b1;
            ph.p800  = (ph.p800  == hapd_pkg::PERIOD_800  - 1) ? '0 : ph.p800  + 1'b1;
            ph.p2000 = (ph.p2000 == hapd_pkg::PERIOD_2000 - 1) ? '0 : ph.p2000 + 1'b1;
            ph.p1000 = (ph.p1000 == hapd_pkg::PERIOD_1000 - 1) ? '0 : ph.p1000 + 1'b1;
        endfunction

        function void check_result(drive_out_t got);
            drive_out_t exp;
            if (due_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result beat with nothing expected: duty %0d rgb %h%h%h gps %b",
                             got.duty, got.red, got.green, got.blue, got.gps);
                return;
            end
            exp = due_q.pop_front();
            if (got.duty !== exp.duty || got.red !== exp.red || got.green !== exp.green ||
                got.blue !== exp.blue || got.gps !== exp.gps) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: duty %0d/%0d red %h/%h green %h/%h blue %h/%h gps %b/%b",
                             exp.duty, got.duty, exp.red, got.red, exp.green, got.green,
                             exp.blue, got.blue, exp.gps, got.gps);
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [1:0]                           alert_level;
    logic [1:0]                           vib_style;
    logic                                 gps_show;
    logic                                 gps_valid;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [7:0]                           motor_duty;
    logic [7:0]                           led_red;
    logic [7:0]                           led_green;
    logic [7:0]                           led_blue;
    logic                                 gps_led;
    logic                                 cfg_write;
    logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [hapd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    haptic_scoreboard sb;
    bit               burst;
    bit               hold_off_req;
    int unsigned      quiet_cycles;

    haptic_alert_output_driver dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .alert_level (alert_level),
        .vib_style   (vib_style),
        .gps_show    (gps_show),
        .gps_valid   (gps_valid),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .motor_duty  (motor_duty),
        .led_red     (led_red),
        .led_green   (led_green),
        .led_blue    (led_blue),
        .gps_led     (gps_led),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= burst || ($urandom_range(99) >= 37);
        end
    end

    // result beats are checked on the edge that takes them
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result({motor_duty, led_red, led_green, led_blue, gps_led});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_tick(input hapd_pkg::level_t lv, input logic [1:0] st,
                             input logic sh, input logic vd);
        while (!burst && $urandom_range(99) < 37) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        alert_level <= lv;
        vib_style   <= st;
        gps_show    <= sh;
        gps_valid   <= vd;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(lv, st, sh, vd);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // let anything still inside settle before registers change
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hapd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [hapd_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [23:0] c_safe, input logic [23:0] c_alert,
                                input logic [23:0] c_warn, input logic [23:0] c_danger,
                                input logic [23:0] strength, input logic [15:0] period);
        write_reg(hapd_pkg::REG_COLOUR_SAFE, c_safe);
        write_reg(hapd_pkg::REG_COLOUR_ALERT, c_alert);
        write_reg(hapd_pkg::REG_COLOUR_WARNING, c_warn);
        write_reg(hapd_pkg::REG_COLOUR_DANGER, c_danger);
        write_reg(hapd_pkg::REG_STRENGTH_LEVELS, strength);
        // junk in the upper byte of the period write must be dropped
        write_reg(hapd_pkg::REG_GPS_BLINK_PERIOD, {8'($urandom), period});
        write_reg(REG_SPARE_A, 24'($urandom));
        write_reg(REG_SPARE_B, 24'($urandom));
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [23:0]      c0, c1, c2, c3, strength;
        logic [15:0]      period;
        hapd_pkg::level_t lv;

        sb           = new();
        burst        = 1'b0;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        alert_level <= '0;
        vib_style   <= '0;
        gps_show    <= 1'b0;
        gps_valid   <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // register defaults straight out of reset
        send_tick(hapd_pkg::LEVEL_SAFE, hapd_pkg::STYLE_STRENGTH, 1'b1, 1'b1);
        send_tick(hapd_pkg::LEVEL_ALERT, hapd_pkg::STYLE_PULSE, 1'b1, 1'b0);
        send_tick(hapd_pkg::LEVEL_WARNING, hapd_pkg::STYLE_TAP, 1'b0, 1'b0);
        send_tick(hapd_pkg::LEVEL_DANGER, STYLE_UNUSED, 1'b1, 1'b0);
        wait_drained();

        // zero blink period: the led flips on every shown tick without a fix
        program_regs(24'h000000, 24'hFFFFFF, 24'hA55AC3, 24'h123456, 24'h007FFF, 16'd0);
        for (int l = 0; l < 4; l++)
            for (int s = 0; s < 4; s++)
                send_tick(hapd_pkg::level_t'(l), 2'(s), 1'b1, 1'b0);
        send_tick(hapd_pkg::LEVEL_SAFE, hapd_pkg::STYLE_STRENGTH, 1'b0, 1'b1);
        send_tick(hapd_pkg::LEVEL_ALERT, hapd_pkg::STYLE_STRENGTH, 1'b1, 1'b1);
        send_tick(hapd_pkg::LEVEL_WARNING, hapd_pkg::STYLE_STRENGTH, 1'b1, 1'b0);
        send_tick(hapd_pkg::LEVEL_DANGER, hapd_pkg::STYLE_STRENGTH, 1'b1, 1'b0);
        wait_drained();

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            c0       = 24'($urandom);
            c1       = 24'($urandom);
            c2       = 24'($urandom);
            c3       = 24'($urandom);
            strength = 24'($urandom);
            period   = 16'($urandom_range(40, 2));
            if (k == 0) begin
                c0 = '1; c1 = '1; c2 = '1; c3 = '1; strength = '1; period = 16'd1;
            end
            else if (k == 1) begin
                c0 = '0; c1 = '0; c2 = '0; c3 = '0; strength = '0; period = 16'hFFFF;
            end
            program_regs(c0, c1, c2, c3, strength, period);
            burst = (k == 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (k == 2 && n == 30)
                    hold_off_req = 1'b1;
                if (k == 2 && n == 60)
                    wait_drained();
                lv = hapd_pkg::level_t'($urandom_range(3));
                send_tick(lv, 2'($urandom_range(3)), $urandom_range(99) < 80,
                          $urandom_range(99) < 25);
            end
            wait_drained();
        end
        burst = 1'b0;

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> haptic_alert_output_driver.f
sv/hapd_pkg.sv
sv/hapd_cfg.sv
sv/hapd_state.sv
sv/hapd_motor.sv
sv/haptic_alert_output_driver.sv
dv/tb_haptic_alert_output_driver.sv
